// ===== rtl/tcw_pkg.sv =====
// Package with the shared types, constants and codes of the text console writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int POS_W  = 11;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELL_W = 16;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_LINE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_BLANK     = 8'h00;
    localparam logic [7:0] ATTR_DEFAULT   = 8'h07;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [4:0]  line_number;
        logic [10:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } rsp_t;

    // Screen store port: byte-lane write port and one registered read port.
    typedef struct packed {
        logic              we_lo;
        logic              we_hi;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_SCROLL,
        S_FLUSH,
        S_POST,
        S_READ,
        S_OUT
    } state_t;

endpackage

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: sequencer, screen store and result register.
//
// Commands enter on the cmd channel (cmd_valid, cmd_stall, cmd) and each one gives
// exactly one result on the rsp channel (rsp_valid, rsp_stall, rsp): the cursor after
// the command and, for a cell read, the cell's character and attribute.
// The block takes one command at a time and holds cmd_stall high while it works.
// After acceptance each command is decoded (S_EXEC); a read of a cell then reads the
// store (S_READ), clear screen sweeps it (S_CLEAR), and a put or newline that scrolls
// runs the scroll sweep (S_SCROLL, S_FLUSH, S_POST). Cursor to line start, a put
// without scrolling, backspace and an out-of-range read finish in decode. Every
// command then passes S_OUT on its way to the result register.
// Clear and scroll are a sweep over the screen store, one cell per cycle through its
// single write port; a scroll step reads the cell one row down and writes it in the
// following cycle. After reset the block runs a clearing pass that sets every cell to
// character zero, attribute 0x07, and accepts no command until it ends.
// The result register lets the next command be accepted while a result waits; a
// stalled result holds, and a finished command waits in the sequencer until the
// result register is free.
module text_console_writer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  tcw_pkg::cmd_t    cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output tcw_pkg::rsp_t    rsp
);
    import tcw_pkg::*;

    ram_req_t          ram_req;
    logic [CELL_W-1:0] rd_data;
    logic              done;
    rsp_t              res;
    logic              rsp_free;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_free  (rsp_free),
        .done      (done),
        .res       (res),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    tcw_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

// ===== rtl/tcw_ram.sv =====
// Screen cell store with byte-lane writes and a registered read port.
module tcw_ram (
    input  logic                              clk,
    input  tcw_pkg::ram_req_t                 req,
    output logic [tcw_pkg::CELL_W-1:0]        rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we_lo)
        begin
            mem[req.waddr][7:0] <= req.wdata[7:0];
        end
        if (req.we_hi)
        begin
            mem[req.waddr][15:8] <= req.wdata[15:8];
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Sequencer of the console writer: cursor, command decode and store sweeps.
module tcw_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  tcw_pkg::cmd_t                 cmd,
    input  logic                          rsp_free,
    output logic                          done,
    output tcw_pkg::rsp_t                 res,
    output tcw_pkg::ram_req_t             ram_req,
    input  logic [tcw_pkg::CELL_W-1:0]    rd_data
);
    import tcw_pkg::*;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   row_base_reg, row_base_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    cmd_t               item_reg, item_next;
    logic               post_reg, post_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_copy_reg, pend_copy_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [7:0]         rchar_reg, rchar_next;
    logic [7:0]         rattr_reg, rattr_next;

    logic [POS_W-1:0]   pos;
    logic               pending;
    logic [ROW_W-1:0]   line_sat;

    assign pos      = row_base_reg + POS_W'(col_reg);
    assign pending  = (row_base_reg == POS_W'(CELLS));
    assign line_sat = (int'(item_reg.line_number) >= ROWS) ? ROW_W'(ROWS - 1)
                                                           : ROW_W'(item_reg.line_number);

    assign res.cursor_pos = pos;
    assign res.read_char  = rchar_reg;
    assign res.read_attr  = rattr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            row_base_reg   <= '0;
            col_reg        <= '0;
            k_reg          <= '0;
            post_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_base_reg   <= row_base_next;
            col_reg        <= col_next;
            k_reg          <= k_next;
            post_reg       <= post_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pend_copy_reg <= pend_copy_next;
        pend_addr_reg <= pend_addr_next;
        rchar_reg     <= rchar_next;
        rattr_reg     <= rattr_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        row_base_next   = row_base_reg;
        col_next        = col_reg;
        k_next          = k_reg;
        item_next       = item_reg;
        post_next       = post_reg;
        pend_valid_next = 1'b0;
        pend_copy_next  = pend_copy_reg;
        pend_addr_next  = pend_addr_reg;
        rchar_next      = rchar_reg;
        rattr_next      = rattr_reg;
        cmd_stall       = 1'b1;
        done            = 1'b0;
        ram_req         = '0;

        // The write half of a scroll step lands in the cycle after its read.
        if (pend_valid_reg)
        begin
            ram_req.we_lo = 1'b1;
            ram_req.we_hi = pend_copy_reg;
            ram_req.waddr = pend_addr_reg;
            ram_req.wdata = pend_copy_reg ? rd_data : {8'h00, CHAR_BLANK};
        end

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_req.we_lo = 1'b1;
                ram_req.we_hi = 1'b1;
                ram_req.waddr = k_reg;
                ram_req.wdata = {ATTR_DEFAULT, CHAR_BLANK};
                k_next        = k_reg + ADDR_W'(1);
                if (k_reg == ADDR_W'(CELLS - 1))
                begin
                    k_next     = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_OUT;
                end
            end

            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    item_next  = cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                rchar_next = 8'h00;
                rattr_next = 8'h00;
                post_next  = 1'b0;
                k_next     = '0;
                state_next = S_OUT;
                case (item_reg.command)
                    CMD_PUT:
                    begin
                        if (item_reg.char_code == CHAR_NEWLINE)
                        begin
                            if (pending)
                            begin
                                state_next = S_SCROLL;
                            end
                            else
                            begin
                                row_base_next = row_base_reg + POS_W'(COLUMNS);
                                col_next      = '0;
                            end
                        end
                        else if (item_reg.char_code == CHAR_BACKSPACE)
                        begin
                            if (pos != '0)
                            begin
                                if (col_reg == '0)
                                begin
                                    row_base_next = row_base_reg - POS_W'(COLUMNS);
                                    col_next      = COL_W'(COLUMNS - 1);
                                end
                                else
                                begin
                                    col_next = col_reg - COL_W'(1);
                                end
                                ram_req.we_lo = 1'b1;
                                ram_req.waddr = ADDR_W'(pos - POS_W'(1));
                                ram_req.wdata = {8'h00, CHAR_BLANK};
                            end
                        end
                        else if (pending)
                        begin
                            // Scroll first, then the byte goes to the last row start.
                            row_base_next = POS_W'(CELLS - COLUMNS);
                            col_next      = COL_W'(1);
                            post_next     = 1'b1;
                            state_next    = S_SCROLL;
                        end
                        else
                        begin
                            ram_req.we_lo = 1'b1;
                            ram_req.waddr = ADDR_W'(pos);
                            ram_req.wdata = {8'h00, item_reg.char_code};
                            if (col_reg == COL_W'(COLUMNS - 1))
                            begin
                                col_next = '0;
                                if (row_base_reg == POS_W'(CELLS - COLUMNS))
                                begin
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    row_base_next = row_base_reg + POS_W'(COLUMNS);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                    end

                    CMD_LINE:
                    begin
                        row_base_next = POS_W'(POS_W'(line_sat) * POS_W'(COLUMNS));
                        col_next      = '0;
                    end

                    CMD_CLEAR:
                    begin
                        row_base_next = '0;
                        col_next      = '0;
                        state_next    = S_CLEAR;
                    end

                    CMD_READ:
                    begin
                        if (int'(item_reg.cell_index) < CELLS)
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = ADDR_W'(item_reg.cell_index);
                            state_next    = S_READ;
                        end
                    end

                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_SCROLL:
            begin
                // Rows above the last copy from one row down; the last row loses its
                // characters and keeps its attributes.
                pend_valid_next = 1'b1;
                pend_addr_next  = k_reg;
                if (int'(k_reg) < CELLS - COLUMNS)
                begin
                    ram_req.re     = 1'b1;
                    ram_req.raddr  = k_reg + ADDR_W'(COLUMNS);
                    pend_copy_next = 1'b1;
                end
                else
                begin
                    pend_copy_next = 1'b0;
                end
                k_next = k_reg + ADDR_W'(1);
                if (k_reg == ADDR_W'(CELLS - 1))
                begin
                    k_next     = '0;
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                state_next = S_POST;
            end

            S_POST:
            begin
                if (post_reg)
                begin
                    ram_req.we_lo = 1'b1;
                    ram_req.waddr = ADDR_W'(CELLS - COLUMNS);
                    ram_req.wdata = {8'h00, item_reg.char_code};
                end
                state_next = S_OUT;
            end

            S_READ:
            begin
                rchar_next = rd_data[7:0];
                rattr_next = rd_data[15:8];
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (rsp_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
